>>> hw/rtl/sorted_priority_queue_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted priority queue core
// Concurrent checks are compiled for simulation and drop out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Check prop on every clk edge outside reset.
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check prop on every clk edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue core.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int VALUE_W = 16;
  localparam int PRIO_W  = 7;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PRIO_ERR = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } op_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  // Broadcast to every cell.
  typedef struct packed {
    op_t    op;
    entry_t item;
  } cmd_t;

  // Handed from a cell to its right-hand neighbor.
  typedef struct packed {
    logic   keep;
    entry_t data;
  } link_t;

endpackage

>>> hw/rtl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds, takes the new entry, or shifts.
// ---------------------------------------------------------------------------
module spq_cell (
  input  logic            clk,
  input  logic            occupied,
  input  spq_pkg::cmd_t   cmd,
  input  spq_pkg::link_t  left_in,
  input  spq_pkg::entry_t right_in,
  output spq_pkg::link_t  link_out
);

  spq_pkg::entry_t data_r;
  spq_pkg::entry_t data_nxt;
  logic            keep;

  // Stay in place when this entry sorts at or before the new one.
  assign keep = occupied && (data_r.prio <= cmd.item.prio);

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      spq_pkg::OP_INSERT: begin
        if (!keep) begin
          data_nxt = left_in.keep ? cmd.item : left_in.data;
        end
      end
      spq_pkg::OP_POP: begin
        data_nxt = right_in;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign link_out.keep = keep;
  assign link_out.data = data_r;

endmodule

>>> hw/rtl/sorted_priority_queue_core.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept sorted by ascending priority in a cell row.
// ---------------------------------------------------------------------------
// Each input transaction is an insert (mode 0) or a pop (mode 1) and yields
// exactly one result transaction in the next cycle. The queue accepts one
// transaction every cycle while in_stall is low: the row of QUEUE_DEPTH
// compare-and-shift cells completes an insert or a pop as it is accepted,
// and the registered result stage lets a new request enter while the
// previous result is being taken. in_stall is raised only while a result is
// held and out_stall is high. Equal priorities leave first in, first out. A
// negative priority returns status 1, an insert into a full queue status 2
// and a pop from an empty queue status 3; none of these change the contents.
// popped_value and popped_priority are zero except on a successful pop, and
// entry_count gives the low five bits of the count after the operation.
// Slot contents have no reset; only the count and out_valid are cleared.
// ---------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_item_value,
  input  logic [7:0]  in_item_priority,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_popped_value,
  output logic [6:0]  out_popped_priority,
  output logic [4:0]  out_entry_count
);

`include "sorted_priority_queue_core_macros.svh"

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Entry count and result registers.
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [15:0]       out_value_r;
  logic [6:0]        out_prio_r;
  logic [4:0]        out_count_r;

  logic              accept;
  spq_pkg::status_t  status;
  spq_pkg::cmd_t     cmd;
  logic [15:0]       pop_value;
  logic [6:0]        pop_prio;
  logic [CNT_W+4:0]  count_ext;

  spq_pkg::link_t    links [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occupied;

  // Hold the input while a finished result is still waiting downstream.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Decode the request against the current fill level.
  always_comb begin
    status    = spq_pkg::ST_OK;
    cmd.op    = spq_pkg::OP_HOLD;
    cmd.item.value = in_item_value;
    cmd.item.prio  = in_item_priority[6:0];
    pop_value = '0;
    pop_prio  = '0;
    count_nxt = count_r;
    if (accept) begin
      if (in_mode == spq_pkg::MODE_INSERT) begin
        if (in_item_priority[7]) begin
          status = spq_pkg::ST_PRIO_ERR;
        end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
          status = spq_pkg::ST_FULL;
        end else begin
          cmd.op    = spq_pkg::OP_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        if (count_r == '0) begin
          status = spq_pkg::ST_EMPTY;
        end else begin
          // Take the head and shift the row toward it.
          cmd.op    = spq_pkg::OP_POP;
          pop_value = links[0].data.value;
          pop_prio  = links[0].data.prio;
          count_nxt = count_r - CNT_W'(1);
        end
      end
    end
  end

  // Row of cells: slot 0 is the head; slots below the count are live.
  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      spq_pkg::link_t  left_in;
      spq_pkg::entry_t right_in;

      assign occupied[gi] = count_r > CNT_W'(gi);

      if (gi == 0) begin : g_head
        // Nothing sits ahead of the head, so it always sees a kept left.
        assign left_in.keep = 1'b1;
        assign left_in.data = cmd.item;
      end else begin : g_body
        assign left_in = links[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        // The tail slot falls out of use on a pop; its content is don't care.
        assign right_in = links[gi].data;
      end else begin : g_mid
        assign right_in = links[gi+1].data;
      end

      spq_cell u_cell (
        .clk      (clk),
        .occupied (occupied[gi]),
        .cmd      (cmd),
        .left_in  (left_in),
        .right_in (right_in),
        .link_out (links[gi])
      );
    end
  endgenerate

  // Count is reported modulo 32.
  assign count_ext = {5'b0, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result with every accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_value_r  <= pop_value;
      out_prio_r   <= pop_prio;
      out_count_r  <= count_ext[4:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_popped_value    = out_value_r;
  assign out_popped_priority = out_prio_r;
  assign out_entry_count     = out_count_r;

  `SPQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH), "count above depth")
  `SPQ_ASSERT(a_insert_grows, clk, rst_n, (cmd.op == spq_pkg::OP_INSERT) |=> (count_r == $past(count_r) + CNT_W'(1)), "insert did not grow count")
  `SPQ_ASSERT(a_fail_zero, clk, rst_n, (out_valid_r && out_status_r != spq_pkg::ST_OK) |-> (out_value_r == '0 && out_prio_r == '0), "failed result carries data")
  `SPQ_ASSERT(a_head_sorted, clk, rst_n, (count_r >= CNT_W'(2)) |-> (links[0].data.prio <= links[1].data.prio), "head out of order")
  `SPQ_ASSERT(a_no_accept_stalled, clk, rst_n, (out_valid_r && out_stall) |-> !accept, "accepted while result stalled")

endmodule
